/* hdl/lcd4_pkg.sv */
// Shared types, command codes and the power-up sequence table for the 4-bit LCD sequencer.
`timescale 1ns / 1ps

package lcd4_pkg;

    typedef struct packed {
        logic [3:0] mode;
        logic [7:0] value;
        logic [5:0] column;
        logic [1:0] line;
        logic       first;
    } t_in_item;

    typedef struct packed {
        logic        pulse;
        logic        register_select;
        logic [3:0]  nibble;
        logic [15:0] wait_us;
        logic        last;
    } t_out_item;

    typedef enum logic [3:0] {
        MODE_INIT        = 4'd0,
        MODE_CLEAR       = 4'd1,
        MODE_HOME        = 4'd2,
        MODE_CURSOR      = 4'd3,
        MODE_DISPLAY     = 4'd4,
        MODE_CURSOR_SHOW = 4'd5,
        MODE_BLINK       = 4'd6,
        MODE_LEFT        = 4'd7,
        MODE_RIGHT       = 4'd8,
        MODE_LTR         = 4'd9,
        MODE_RTL         = 4'd10,
        MODE_AUTOSCROLL  = 4'd11,
        MODE_CHAR        = 4'd12
    } t_mode;

    typedef enum logic {
        JOB_BYTE = 1'b0,
        JOB_INIT = 1'b1
    } t_job_kind;

    // One decoded request waiting to be split into nibble beats.
    typedef struct packed {
        t_job_kind   kind;
        logic        rs;
        logic [7:0]  data;
        logic [15:0] wait_us;
        logic        two_line;
    } t_job;

    typedef enum logic {
        CFG_ROWS    = 1'b0,
        CFG_COLUMNS = 1'b1
    } t_cfg_index;

    localparam logic [7:0] CMD_CLEAR        = 8'h01;
    localparam logic [7:0] CMD_HOME         = 8'h02;
    localparam logic [7:0] CMD_ENTRY_MODE   = 8'h04;
    localparam logic [7:0] CMD_DISPLAY_CTRL = 8'h08;
    localparam logic [7:0] CMD_SHIFT_LEFT   = 8'h18;
    localparam logic [7:0] CMD_SHIFT_RIGHT  = 8'h1C;
    localparam logic [7:0] CMD_FUNCTION_SET = 8'h20;
    localparam logic [7:0] FUNC_TWO_LINE    = 8'h08;
    localparam logic [7:0] CMD_SET_DDRAM    = 8'h80;
    localparam logic [3:0] NIB_WAKE         = 4'h3;
    localparam logic [7:0] CHAR_NEWLINE     = 8'h0A;

    localparam logic [2:0] DISPLAY_RESET = 3'd4;
    localparam logic [1:0] ENTRY_RESET   = 2'd2;
    localparam logic [2:0] ROWS_RESET    = 3'd2;
    localparam logic [5:0] COLUMNS_RESET = 6'd16;

    localparam logic [15:0] WAIT_NONE     = 16'd0;
    localparam logic [15:0] WAIT_POWER_UP = 16'd45000;
    localparam logic [15:0] WAIT_WAKE     = 16'd4500;
    localparam logic [15:0] WAIT_4BIT     = 16'd100;
    localparam logic [15:0] WAIT_CLEAR    = 16'd3000;
    localparam logic [15:0] WAIT_INIT_END = 16'd7500;

    localparam logic [3:0] INIT_LAST_IDX = 4'd12;
    localparam logic [3:0] BYTE_LAST_IDX = 4'd1;

    localparam logic [7:0] ROW_BASE [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

    // Clamp a requested row to the configured line count and to the last row.
    function automatic logic [1:0] clamp_row(input logic [1:0] row, input logic [2:0] rows);
        logic [2:0] lim;
        logic [2:0] r;
        lim = (rows == 3'd0) ? 3'd1 : rows;
        r   = ({1'b0, row} >= lim) ? (lim - 3'd1) : {1'b0, row};
        return (r > 3'd3) ? 2'd3 : r[1:0];
    endfunction

    function automatic logic [7:0] cursor_cmd(input logic [5:0] col, input logic [1:0] row,
                                              input logic [2:0] rows);
        logic [7:0] sum;
        sum = {2'b00, col} + ROW_BASE[clamp_row(row, rows)];
        return CMD_SET_DDRAM | sum;
    endfunction

    // The thirteen beats of the power-up sequence, picked by position.
    function automatic t_out_item init_beat(input logic [3:0] idx, input logic two_line);
        t_out_item  b;
        logic [7:0] func;
        logic [7:0] disp;
        logic [7:0] entr;
        func = CMD_FUNCTION_SET | (two_line ? FUNC_TWO_LINE : 8'h00);
        disp = CMD_DISPLAY_CTRL | {5'd0, DISPLAY_RESET};
        entr = CMD_ENTRY_MODE | {6'd0, ENTRY_RESET};
        b.pulse           = 1'b1;
        b.register_select = 1'b0;
        b.nibble          = 4'h0;
        b.wait_us         = WAIT_NONE;
        b.last            = 1'b0;
        case (idx)
            4'd0: begin
                b.pulse   = 1'b0;
                b.wait_us = WAIT_POWER_UP;
            end
            4'd1, 4'd2, 4'd3: begin
                b.nibble  = NIB_WAKE;
                b.wait_us = WAIT_WAKE;
            end
            4'd4: begin
                b.nibble  = CMD_FUNCTION_SET[7:4];
                b.wait_us = WAIT_4BIT;
            end
            4'd5:  b.nibble = func[7:4];
            4'd6:  b.nibble = func[3:0];
            4'd7:  b.nibble = disp[7:4];
            4'd8:  b.nibble = disp[3:0];
            4'd9:  b.nibble = entr[7:4];
            4'd10: b.nibble = entr[3:0];
            4'd11: b.nibble = CMD_CLEAR[7:4];
            4'd12: begin
                b.nibble  = CMD_CLEAR[3:0];
                b.wait_us = WAIT_INIT_END;
                b.last    = 1'b1;
            end
            default: b.pulse = 1'b0;
        endcase
        return b;
    endfunction

endpackage

/* hdl/lcd4_decode.sv */
// Request decoder holding the configuration, display-control, entry-mode and line state.
`timescale 1ns / 1ps

module lcd4_decode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  lcd4_pkg::t_in_item  i_item,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [5:0]          i_cfg_data,
    output logic                o_has_job,
    output lcd4_pkg::t_job      o_job
);
    import lcd4_pkg::*;

    logic [2:0] r_rows;
    logic [5:0] r_columns;
    logic [2:0] r_display;
    logic [1:0] r_entry;
    logic [1:0] r_line;
    logic [2:0] n_display;
    logic [1:0] n_entry;
    logic [1:0] n_line;
    logic [1:0] w_line0;
    logic [1:0] w_line1;
    logic [2:0] w_bit;
    logic       w_on;
    logic [5:0] w_nl_col;

    always_comb begin
        n_display = r_display;
        n_entry   = r_entry;
        n_line    = r_line;
        o_has_job = 1'b0;
        o_job.kind     = JOB_BYTE;
        o_job.rs       = 1'b0;
        o_job.data     = 8'h00;
        o_job.wait_us  = WAIT_NONE;
        o_job.two_line = (r_rows > 3'd1);
        w_on     = (i_item.value != 8'h00);
        w_line0  = i_item.first ? 2'd0 : r_line;
        w_line1  = (w_line0 < 2'd3) ? (w_line0 + 2'd1) : 2'd3;
        w_nl_col = r_entry[1] ? 6'd0 : r_columns;
        case (t_mode'(i_item.mode))
            MODE_CURSOR_SHOW: w_bit = 3'b010;
            MODE_BLINK:       w_bit = 3'b001;
            default:          w_bit = 3'b100;
        endcase

        case (t_mode'(i_item.mode))
            MODE_INIT: begin
                o_has_job  = 1'b1;
                o_job.kind = JOB_INIT;
                n_display  = DISPLAY_RESET;
                n_entry    = ENTRY_RESET;
            end
            MODE_CLEAR: begin
                o_has_job     = 1'b1;
                o_job.data    = CMD_CLEAR;
                o_job.wait_us = WAIT_CLEAR;
            end
            MODE_HOME: begin
                o_has_job     = 1'b1;
                o_job.data    = CMD_HOME;
                o_job.wait_us = WAIT_CLEAR;
            end
            MODE_CURSOR: begin
                o_has_job  = 1'b1;
                o_job.data = cursor_cmd(i_item.column, i_item.line, r_rows);
            end
            MODE_DISPLAY, MODE_CURSOR_SHOW, MODE_BLINK: begin
                n_display  = w_on ? (r_display | w_bit) : (r_display & ~w_bit);
                o_has_job  = 1'b1;
                o_job.data = CMD_DISPLAY_CTRL | {5'd0, n_display};
            end
            MODE_LEFT: begin
                o_has_job  = 1'b1;
                o_job.data = CMD_SHIFT_LEFT;
            end
            MODE_RIGHT: begin
                o_has_job  = 1'b1;
                o_job.data = CMD_SHIFT_RIGHT;
            end
            MODE_LTR, MODE_RTL, MODE_AUTOSCROLL: begin
                if (t_mode'(i_item.mode) == MODE_LTR) begin
                    n_entry = r_entry | 2'b10;
                end else if (t_mode'(i_item.mode) == MODE_RTL) begin
                    n_entry = r_entry & 2'b01;
                end else begin
                    n_entry = w_on ? (r_entry | 2'b01) : (r_entry & 2'b10);
                end
                o_has_job  = 1'b1;
                o_job.data = CMD_ENTRY_MODE | {6'd0, n_entry};
            end
            MODE_CHAR: begin
                n_line = w_line0;
                if (i_item.value == CHAR_NEWLINE) begin
                    // A newline steps to the next message line and re-addresses it.
                    n_line     = w_line1;
                    o_has_job  = 1'b1;
                    o_job.data = cursor_cmd(w_nl_col, w_line1, r_rows);
                end else if (w_on) begin
                    o_has_job  = 1'b1;
                    o_job.rs   = 1'b1;
                    o_job.data = i_item.value;
                end
            end
            default: begin
                o_has_job = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows    <= ROWS_RESET;
            r_columns <= COLUMNS_RESET;
            r_display <= DISPLAY_RESET;
            r_entry   <= ENTRY_RESET;
            r_line    <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                if (t_cfg_index'(i_cfg_index) == CFG_ROWS) begin
                    r_rows <= i_cfg_data[2:0];
                end else begin
                    r_columns <= i_cfg_data;
                end
            end
            if (i_accept) begin
                r_display <= n_display;
                r_entry   <= n_entry;
                r_line    <= n_line;
            end
        end
    end

endmodule

/* hdl/lcd4_emit.sv */
// Job register and nibble stepper feeding the registered output beat.
`timescale 1ns / 1ps

module lcd4_emit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_has_job,
    input  lcd4_pkg::t_job      i_job,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lcd4_pkg::t_out_item o_out_data
);
    import lcd4_pkg::*;

    t_job       r_job;
    logic       r_job_valid;
    logic [3:0] r_idx;
    t_out_item  r_out;
    logic       r_out_valid;
    t_out_item  w_beat;
    logic [3:0] w_last_idx;
    logic       w_load;
    logic       w_done;
    logic       w_accept;

    always_comb begin
        w_last_idx = (r_job.kind == JOB_INIT) ? INIT_LAST_IDX : BYTE_LAST_IDX;
        if (r_job.kind == JOB_INIT) begin
            w_beat = init_beat(r_idx, r_job.two_line);
        end else begin
            w_beat.pulse           = 1'b1;
            w_beat.register_select = r_job.rs;
            w_beat.nibble          = r_idx[0] ? r_job.data[3:0] : r_job.data[7:4];
            w_beat.wait_us         = r_idx[0] ? r_job.wait_us : WAIT_NONE;
            w_beat.last            = r_idx[0];
        end
    end

    assign w_load     = r_job_valid && (!r_out_valid || i_out_ready);
    assign w_done     = w_load && (r_idx == w_last_idx);
    assign o_in_ready = !r_job_valid || w_done;
    assign w_accept   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= 4'd0;
        end else begin
            if (w_accept && i_has_job) begin
                r_job_valid <= 1'b1;
                r_idx       <= 4'd0;
            end else if (w_done) begin
                r_job_valid <= 1'b0;
            end else if (w_load) begin
                r_idx <= r_idx + 4'd1;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_has_job) begin
            r_job <= i_job;
        end
        if (w_load) begin
            r_out <= w_beat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid |-> (r_idx <= w_last_idx))
        else $error("nibble index ran past the end of its job");

    a_busy_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_job_valid && !w_done))
        else $error("input stalled with no job in progress");

    a_last_frees_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_done && !(w_accept && i_has_job)) |=> !r_job_valid)
        else $error("job stayed active after its final beat");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_out_valid && !r_job_valid))
        else $error("reset left a beat or job pending");

endmodule

/* hdl/char_lcd_4bit_command_sequencer.sv */
// Top level of the 4-bit character LCD command sequencer.
`timescale 1ns / 1ps

// Each accepted request is decoded in the cycle it arrives and then sent out as one
// nibble beat per cycle while the output is ready, from a single output register, so
// the nibble stepper sets the rate: most requests give a high and a low nibble beat,
// power-up init gives thirteen beats, and requests that yield no beat (a zero
// character, unused modes) give none. A request's first beat passes through the job
// register and then the output register, and a new request is taken in the same cycle
// the previous one's final beat is loaded. Configuration writes apply to the next request.
module char_lcd_4bit_command_sequencer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lcd4_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lcd4_pkg::t_out_item o_out_data,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [5:0]          i_cfg_data
);
    import lcd4_pkg::*;

    logic w_accept;
    logic w_has_job;
    t_job w_job;

    assign w_accept = i_in_valid && o_in_ready;

    lcd4_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_item      (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_has_job   (w_has_job),
        .o_job       (w_job)
    );

    lcd4_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_has_job   (w_has_job),
        .i_job       (w_job),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
